// File: design/pcl_pkg.sv
// Shared types and constants of the page catalogue.
package pcl_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = IDX_W + 1;

   localparam logic [16:0] HDR_UNKNOWN = 17'h10000;
   localparam logic [6:0]  MAX_RESET   = 7'd64;

   typedef struct packed {
      logic [3:0]  magazine;
      logic [7:0]  page;
      logic [47:0] first_frame;
      logic [15:0] appearances;
      logic        subtitle;
      logic [16:0] header_seen;
      logic [39:0] touch;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_UPD,
      ST_EVSCAN,
      ST_EVICT,
      ST_DONE
   } state_type;

endpackage

// File: design/pcl_ram.sv
// Simple dual port synchronous RAM with a registered read port.
module pcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/page_catalogue_lru.sv
// Page catalogue: keyed table of page sightings with LRU eviction.
//
// Usage:
//  req_* channel carries one page sighting per beat (req_valid / req_stall).
//  rsp_* channel returns exactly one result beat per sighting.
//  csr_* channel writes the page bound (csr_valid / csr_ready, ready always high);
//  write it only while no sighting is in flight.
// Processing:
//  Entries live in one RAM. Each sighting takes a lookup pass over all 64
//  entries and one update step. After an insert that lifts occupancy above
//  the page bound, one scan pass and one eviction step follow per entry
//  evicted; an insert into a full table replaces the oldest-touched entry.
//  One sighting is processed at a time; req_stall is high while busy.
// Reset: synchronous, clears all valid bits, occupancy, touch counter and
//  the truncated flag; the page bound returns to 64. No clearing pass needed.
// Stall: a result waits in the output register while rsp_stall is high;
//  a finished sighting holds in its last state until the register frees.
module page_catalogue_lru (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_magazine,
   input  logic [7:0]  req_page_number,
   input  logic        req_subtitle,
   input  logic [15:0] req_header_index,
   input  logic [47:0] req_frame_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_slot,
   output logic        rsp_was_new,
   output logic [15:0] rsp_appearances,
   output logic [47:0] rsp_first_frame,
   output logic        rsp_subtitle_mark,
   output logic [6:0]  rsp_evicted_count,
   output logic [3:0]  rsp_evicted_magazine,
   output logic [7:0]  rsp_evicted_page,
   output logic        rsp_truncated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);
   import pcl_pkg::*;

   state_type state_ff, state_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [39:0] touch_ff, touch_in;
   logic trunc_ff, trunc_in;
   logic [6:0] max_ff;

   logic [3:0]  mag_ff, mag_in;
   logic [7:0]  pg_ff, pg_in;
   logic        sub_ff, sub_in;
   logic [15:0] hdr_ff, hdr_in;
   logic [47:0] frame_ff, frame_in;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;

   logic hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   entry_type hit_rec_ff, hit_rec_in;
   logic free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic min_ok_ff, min_ok_in;
   logic [IDX_W-1:0] min_idx_ff, min_idx_in;
   logic [39:0] min_touch_ff, min_touch_in;
   logic [3:0] min_mag_ff, min_mag_in;
   logic [7:0] min_pg_ff, min_pg_in;

   logic [IDX_W-1:0] slot_ff, slot_in;
   logic new_ff, new_in;
   entry_type res_ff, res_in;
   logic [CNT_W-1:0] evc_ff, evc_in;
   logic [3:0] evm_ff, evm_in;
   logic [7:0] evp_ff, evp_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [5:0]  o_slot_ff;
   logic        o_new_ff;
   logic [15:0] o_app_ff;
   logic [47:0] o_first_ff;
   logic        o_sub_ff;
   logic [6:0]  o_evc_ff;
   logic [3:0]  o_evm_ff;
   logic [7:0]  o_evp_ff;
   logic        o_trunc_ff;
   logic        load;

   logic wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;
   logic [ENTRY_W-1:0] rd_raw;

   logic [CNT_W-1:0] bound;
   entry_type base;
   logic accept;

   pcl_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );
   assign rd_data = entry_type'(rd_raw);

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      if (max_ff == 7'd0) begin
         bound = CNT_W'(1);
      end else if (max_ff > 7'(CAPACITY)) begin
         bound = CNT_W'(CAPACITY);
      end else begin
         bound = CNT_W'(max_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      occ_in = occ_ff;
      touch_in = touch_ff;
      trunc_in = trunc_ff;
      mag_in = mag_ff;
      pg_in = pg_ff;
      sub_in = sub_ff;
      hdr_in = hdr_ff;
      frame_in = frame_ff;
      cnt_in = cnt_ff;
      pend_in = 1'b0;
      pidx_in = cnt_ff[IDX_W-1:0];
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      hit_rec_in = hit_rec_ff;
      free_in = free_ff;
      free_idx_in = free_idx_ff;
      min_ok_in = min_ok_ff;
      min_idx_in = min_idx_ff;
      min_touch_in = min_touch_ff;
      min_mag_in = min_mag_ff;
      min_pg_in = min_pg_ff;
      slot_in = slot_ff;
      new_in = new_ff;
      res_in = res_ff;
      evc_in = evc_ff;
      evm_in = evm_ff;
      evp_in = evp_ff;
      wr_en = 1'b0;
      wr_addr = slot_ff;
      wr_data = res_ff;
      rd_en = 1'b0;
      rd_addr = cnt_ff[IDX_W-1:0];
      load = 1'b0;
      base = hit_rec_ff;

      if (state_ff == ST_LOOK || state_ff == ST_EVSCAN) begin
         rd_en = !cnt_ff[CNT_W-1];
         pend_in = !cnt_ff[CNT_W-1];
         if (!cnt_ff[CNT_W-1]) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
         if (pend_ff) begin
            if (valid_ff[pidx_ff]) begin
               if (!hit_ff && rd_data.magazine == mag_ff && rd_data.page == pg_ff) begin
                  hit_in = 1'b1;
                  hit_idx_in = pidx_ff;
                  hit_rec_in = rd_data;
               end
               if (!min_ok_ff || rd_data.touch < min_touch_ff) begin
                  min_ok_in = 1'b1;
                  min_idx_in = pidx_ff;
                  min_touch_in = rd_data.touch;
                  min_mag_in = rd_data.magazine;
                  min_pg_in = rd_data.page;
               end
            end else if (!free_ff) begin
               free_in = 1'b1;
               free_idx_in = pidx_ff;
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mag_in = req_magazine;
               pg_in = req_page_number;
               sub_in = req_subtitle;
               hdr_in = req_header_index;
               frame_in = req_frame_number;
               cnt_in = '0;
               hit_in = 1'b0;
               free_in = 1'b0;
               min_ok_in = 1'b0;
               evc_in = '0;
               evm_in = '0;
               evp_in = '0;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (cnt_ff[CNT_W-1] && !pend_ff) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (!hit_ff) begin
               base.magazine = mag_ff;
               base.page = pg_ff;
               base.first_frame = frame_ff;
               base.appearances = '0;
               base.subtitle = 1'b0;
               base.header_seen = HDR_UNKNOWN;
               base.touch = '0;
            end
            touch_in = touch_ff + 40'd1;
            base.touch = touch_in;
            base.subtitle = base.subtitle | sub_ff;
            if (base.header_seen != {1'b0, hdr_ff}) begin
               base.header_seen = {1'b0, hdr_ff};
               if (base.appearances != 16'hFFFF) begin
                  base.appearances = base.appearances + 16'd1;
               end
            end
            res_in = base;
            new_in = !hit_ff;
            if (hit_ff) begin
               slot_in = hit_idx_ff;
            end else if (free_ff) begin
               slot_in = free_idx_ff;
               occ_in = occ_ff + CNT_W'(1);
            end else begin
               slot_in = min_idx_ff;
               evc_in = CNT_W'(1);
               evm_in = min_mag_ff;
               evp_in = min_pg_ff;
               trunc_in = 1'b1;
            end
            valid_in[slot_in] = 1'b1;
            wr_en = 1'b1;
            wr_addr = slot_in;
            wr_data = base;
            if (!hit_ff && occ_in > bound) begin
               cnt_in = '0;
               min_ok_in = 1'b0;
               state_in = ST_EVSCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_EVSCAN: begin
            if (cnt_ff[CNT_W-1] && !pend_ff) begin
               state_in = min_ok_ff ? ST_EVICT : ST_DONE;
            end
         end
         ST_EVICT: begin
            valid_in[min_idx_ff] = 1'b0;
            occ_in = occ_ff - CNT_W'(1);
            evc_in = evc_ff + CNT_W'(1);
            evm_in = min_mag_ff;
            evp_in = min_pg_ff;
            trunc_in = 1'b1;
            cnt_in = '0;
            min_ok_in = 1'b0;
            state_in = (occ_in > bound) ? ST_EVSCAN : ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         occ_ff <= '0;
         touch_ff <= '0;
         trunc_ff <= 1'b0;
         max_ff <= MAX_RESET;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         occ_ff <= occ_in;
         touch_ff <= touch_in;
         trunc_ff <= trunc_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff <= pend_in;
         if (csr_valid && csr_ready) begin
            max_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      pg_ff <= pg_in;
      sub_ff <= sub_in;
      hdr_ff <= hdr_in;
      frame_ff <= frame_in;
      cnt_ff <= cnt_in;
      pidx_ff <= pidx_in;
      hit_ff <= hit_in;
      hit_idx_ff <= hit_idx_in;
      hit_rec_ff <= hit_rec_in;
      free_ff <= free_in;
      free_idx_ff <= free_idx_in;
      min_ok_ff <= min_ok_in;
      min_idx_ff <= min_idx_in;
      min_touch_ff <= min_touch_in;
      min_mag_ff <= min_mag_in;
      min_pg_ff <= min_pg_in;
      slot_ff <= slot_in;
      new_ff <= new_in;
      res_ff <= res_in;
      evc_ff <= evc_in;
      evm_ff <= evm_in;
      evp_ff <= evp_in;
      if (load) begin
         o_slot_ff <= 6'(slot_ff);
         o_new_ff <= new_ff;
         o_app_ff <= res_ff.appearances;
         o_first_ff <= res_ff.first_frame;
         o_sub_ff <= res_ff.subtitle;
         o_evc_ff <= 7'(evc_ff);
         o_evm_ff <= evm_ff;
         o_evp_ff <= evp_ff;
         o_trunc_ff <= trunc_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_slot = o_slot_ff;
   assign rsp_was_new = o_new_ff;
   assign rsp_appearances = o_app_ff;
   assign rsp_first_frame = o_first_ff;
   assign rsp_subtitle_mark = o_sub_ff;
   assign rsp_evicted_count = o_evc_ff;
   assign rsp_evicted_magazine = o_evm_ff;
   assign rsp_evicted_page = o_evp_ff;
   assign rsp_truncated = o_trunc_ff;

   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      occ_ff == CNT_W'($countones(valid_ff)))
      else $error("occupancy out of step with valid bits");

   a_accept_starts_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOOK)
      else $error("accepted beat did not start lookup");

   a_evict_sets_trunc: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVICT |=> trunc_ff)
      else $error("eviction left truncated clear");

   a_rsp_evict_trunc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && o_evc_ff != 7'd0) |-> o_trunc_ff)
      else $error("evicting result without truncated");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the page catalogue with LRU eviction.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pcl_pkg::*;

   localparam int LIMIT = 2000000;

   typedef struct {
      logic [5:0]  slot;
      logic        was_new;
      logic [15:0] appearances;
      logic [47:0] first_frame;
      logic        subtitle_mark;
      logic [6:0]  evicted_count;
      logic [3:0]  evicted_magazine;
      logic [7:0]  evicted_page;
      logic        truncated;
   } sighting_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_valid = 0;
   logic req_stall, rsp_valid, csr_ready;
   logic [3:0]  req_magazine = 0;
   logic [7:0]  req_page_number = 0;
   logic        req_subtitle = 0;
   logic [15:0] req_header_index = 0;
   logic [47:0] req_frame_number = 0;
   logic [6:0]  csr_data = 0;
   logic [5:0]  rsp_slot;
   logic        rsp_was_new, rsp_subtitle_mark, rsp_truncated;
   logic [15:0] rsp_appearances;
   logic [47:0] rsp_first_frame;
   logic [6:0]  rsp_evicted_count;
   logic [3:0]  rsp_evicted_magazine;
   logic [7:0]  rsp_evicted_page;

   page_catalogue_lru dut (.*);

   // predictor state
   logic        cat_valid [CAPACITY];
   logic [3:0]  cat_mag [CAPACITY];
   logic [7:0]  cat_page [CAPACITY];
   logic [47:0] cat_first [CAPACITY];
   logic [15:0] cat_apps [CAPACITY];
   logic        cat_sub [CAPACITY];
   logic [16:0] cat_hdr [CAPACITY];
   logic [39:0] cat_touch [CAPACITY];
   logic [39:0] touch_now;
   int          occupancy;
   logic        trunc_flag;
   logic [6:0]  page_bound;

   sighting_type expected_q[$];
   int  errors = 0;
   int  cycles = 0;
   bit  calm = 0;

   initial forever #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   function automatic int oldest_entry();
      int best = -1;
      for (int i = 0; i < CAPACITY; i++)
         if (cat_valid[i] && (best < 0 || cat_touch[i] < cat_touch[best])) best = i;
      if (best >= 0) begin
         cat_valid[best] = 0;
         if (occupancy > 0) occupancy--;
         trunc_flag = 1;
      end
      return best;
   endfunction

   function automatic sighting_type predict_sighting(logic [3:0] mag, logic [7:0] pg,
         logic sub, logic [15:0] hdr, logic [47:0] frame);
      sighting_type r;
      int s = -1, v, bound;
      for (int i = 0; i < CAPACITY; i++)
         if (s < 0 && cat_valid[i] && cat_mag[i] == mag && cat_page[i] == pg) s = i;
      r.was_new = (s < 0);
      r.evicted_count = 0;
      r.evicted_magazine = 0;
      r.evicted_page = 0;
      if (r.was_new) begin
         for (int i = 0; i < CAPACITY; i++)
            if (s < 0 && !cat_valid[i]) s = i;
         if (s < 0) begin
            s = oldest_entry();
            r.evicted_count++;
            r.evicted_magazine = cat_mag[s];
            r.evicted_page = cat_page[s];
         end
         cat_valid[s] = 1;
         cat_mag[s] = mag;
         cat_page[s] = pg;
         cat_first[s] = frame;
         cat_apps[s] = 0;
         cat_sub[s] = 0;
         cat_hdr[s] = HDR_UNKNOWN;
         occupancy++;
      end
      touch_now = touch_now + 1;
      cat_touch[s] = touch_now;
      if (sub) cat_sub[s] = 1;
      if (cat_hdr[s] != {1'b0, hdr}) begin
         cat_hdr[s] = {1'b0, hdr};
         if (cat_apps[s] != 16'hFFFF) cat_apps[s]++;
      end
      if (r.was_new) begin
         bound = (page_bound == 0) ? 1 : (page_bound > CAPACITY ? CAPACITY : page_bound);
         while (occupancy > bound) begin
            v = oldest_entry();
            if (v < 0) break;
            r.evicted_count++;
            r.evicted_magazine = cat_mag[v];
            r.evicted_page = cat_page[v];
         end
      end
      r.slot = 6'(s);
      r.appearances = cat_apps[s];
      r.first_frame = cat_first[s];
      r.subtitle_mark = cat_sub[s];
      r.truncated = trunc_flag;
      return r;
   endfunction

   // result checker and stall generator
   always @(posedge clock) begin
      sighting_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result beat slot %0d", $time, rsp_slot);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if ({rsp_slot, rsp_was_new, rsp_appearances, rsp_first_frame,
                 rsp_subtitle_mark, rsp_evicted_count, rsp_evicted_magazine,
                 rsp_evicted_page, rsp_truncated} !==
                {e.slot, e.was_new, e.appearances, e.first_frame, e.subtitle_mark,
                 e.evicted_count, e.evicted_magazine, e.evicted_page, e.truncated}) begin
               $display("%0t: mismatch expected slot %0d new %0b apps %0d first %0h sub %0b",
                        $time, e.slot, e.was_new, e.appearances, e.first_frame,
                        e.subtitle_mark);
               $display("   ev %0d %0d/%0h trunc %0b; actual slot %0d new %0b apps %0d",
                        e.evicted_count, e.evicted_magazine, e.evicted_page, e.truncated,
                        rsp_slot, rsp_was_new, rsp_appearances);
               $display("   first %0h sub %0b ev %0d %0d/%0h trunc %0b", rsp_first_frame,
                        rsp_subtitle_mark, rsp_evicted_count, rsp_evicted_magazine,
                        rsp_evicted_page, rsp_truncated);
               errors++;
            end
         end
      end
      rsp_stall <= !calm && ($urandom_range(99) < 21);
   end

   task automatic send_sighting(logic [3:0] mag, logic [7:0] pg, logic sub,
         logic [15:0] hdr, logic [47:0] frame);
      while (!calm && $urandom_range(99) < 21) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_magazine <= mag;
      req_page_number <= pg;
      req_subtitle <= sub;
      req_header_index <= hdr;
      req_frame_number <= frame;
      do @(posedge clock); while (req_stall);
      expected_q.insert(expected_q.size(), predict_sighting(mag, pg, sub, hdr, frame));
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_bound(logic [6:0] value);
      drain();
      csr_valid <= 1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      page_bound = value;
      csr_valid <= 0;
   endtask

   function automatic logic [47:0] rand_frame();
      return 48'({$urandom(), $urandom()});
   endfunction

   task automatic test_directed_extremes();
      send_sighting(1, 0, 0, 0, 0);
      send_sighting(8, 255, 1, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
      send_sighting(1, 0, 0, 0, 5);
      send_sighting(1, 0, 1, 1, 6);
      send_sighting(15, 8'hAA, 0, 16'h5555, 48'hAAAA_AAAA_AAAA);
      send_sighting(0, 8'h55, 1, 16'hAAAA, 48'h5555_5555_5555);
      send_sighting(8, 255, 0, 16'hFFFF, 1);
      send_sighting(8, 255, 0, 16'hFFFE, 2);
   endtask

   task automatic test_small_bounds();
      write_bound(1);
      for (int i = 0; i < 6; i++)
         send_sighting(4'(i + 1), 8'(i), i[0], 16'(i), rand_frame());
      write_bound(0);
      send_sighting(2, 2, 0, 3, 1);
      send_sighting(3, 3, 0, 3, 1);
      send_sighting(3, 3, 1, 4, 1);
   endtask

   task automatic test_full_table();
      write_bound(127);
      for (int i = 0; i < 70; i++) send_sighting(5, 8'(i), 0, 16'(i), rand_frame());
      write_bound(64);
      for (int i = 0; i < 8; i++) send_sighting(6, 8'(i), 1, 16'(i), rand_frame());
   endtask

   task automatic test_lowered_bound();
      write_bound(3);
      send_sighting(6, 7, 0, 9, 1);
      send_sighting(7, 7, 0, 9, 1);
   endtask

   task automatic test_saturation();
      write_bound(64);
      for (int i = 0; i < 65540; i++) begin
         calm = 1;
         send_sighting(4, 44, 0, i[15:0], 48'(i));
      end
      send_sighting(4, 44, 0, 16'h0003, 0);
      calm = 0;
   endtask

   task automatic test_random(int count);
      int n = 0, pool, b;
      logic [15:0] hdr = 0;
      while (n < count) begin
         b = $urandom_range(7);
         write_bound(7'(b == 0 ? $urandom_range(1, 4) : b == 1 ? 64 : b == 2 ? 127 :
                        b == 3 ? 0 : $urandom_range(1, 127)));
         pool = $urandom_range(1, 3) == 1 ? 200 : $urandom_range(2, 20);
         for (int k = 0; k < 220; k++) begin
            if (k == 60) calm = 1;
            if (k == 140) calm = 0;
            if ($urandom_range(3) != 0) hdr = 16'($urandom());
            send_sighting(4'($urandom_range(9) == 0 ? $urandom() : $urandom_range(1, 8)),
                          8'($urandom_range(pool - 1)), 1'($urandom_range(1)), hdr,
                          rand_frame());
            n++;
         end
      end
   endtask

   initial begin
      for (int i = 0; i < CAPACITY; i++) cat_valid[i] = 0;
      touch_now = 0;
      occupancy = 0;
      trunc_flag = 0;
      page_bound = MAX_RESET;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed_extremes();
      test_small_bounds();
      test_full_table();
      test_lowered_bound();
      test_random(1750);
      drain();
      if (errors == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end
endmodule
